@@ rtl/tcfp_pkg.sv @@
// Shared types and constants of the time command frame parser.
// Holds the register index codes, the queued job record and the result record.
// No dependencies.
`default_nettype none

package tcfp_pkg;

  typedef enum logic [2:0] {
    RegStartCode     = 3'd0,
    RegCodeGetTime   = 3'd1,
    RegCodeResetTime = 3'd2,
    RegCodeSetMode   = 3'd3,
    RegCodeHour      = 3'd4,
    RegCodeMinute    = 3'd5,
    RegCodeSecond    = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    UpdNone   = 2'd0,
    UpdHour   = 2'd1,
    UpdMinute = 2'd2,
    UpdSecond = 2'd3
  } update_kind_e;

  localparam int unsigned ReplyItems = 12;

  typedef struct packed {
    logic              is_get;
    logic              frame_valid;
    logic              reset_request;
    update_kind_e      update_kind;
    logic [7:0]        update_value;
    logic [7:0]        start;
    logic [2:0][7:0]   code;
    logic [2:0][7:0]   now;
  } job_t;

  typedef struct packed {
    logic         has_tx;
    logic [7:0]   tx_byte;
    logic         frame_valid;
    logic         reset_request;
    update_kind_e update_kind;
    logic [7:0]   update_value;
    logic         last;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/tcfp_front.sv @@
// Front end: configuration registers, frame assembly, checksum check and dispatch.
// Produces one job per accepted byte. Depends on tcfp_pkg.
`default_nettype none

module tcfp_front import tcfp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       accept_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [7:0] now_hour_i,
  input  wire logic [7:0] now_minute_i,
  input  wire logic [7:0] now_second_i,
  output job_t            job_o
);

  logic [7:0] start_q, get_q, rst_code_q, mode_q, hour_q, minute_q, second_q;
  logic [1:0] pos_q, pos_sel;
  logic [7:0] store_q [3];
  logic       set_en_q, set_en_d;
  logic [7:0] cmd, par;
  logic       good;

  always_comb begin
    pos_sel  = (rx_byte_i == start_q) ? 2'd0 : pos_q;
    cmd      = store_q[1];
    par      = store_q[2];
    good     = (store_q[0] == start_q) && (rx_byte_i == 8'(cmd + par));
    set_en_d = set_en_q;
    job_o    = '0;
    job_o.start  = start_q;
    job_o.code   = {second_q, minute_q, hour_q};
    job_o.now    = {now_second_i, now_minute_i, now_hour_i};
    if (pos_sel == 2'd3 && good) begin
      job_o.frame_valid = 1'b1;
      priority if (cmd == get_q) begin
        job_o.is_get = 1'b1;
      end else if (cmd == rst_code_q) begin
        job_o.reset_request = 1'b1;
      end else if (cmd == mode_q) begin
        set_en_d = (par != 8'd0);
      end else if (cmd == hour_q) begin
        if (set_en_q) begin
          job_o.update_kind  = UpdHour;
          job_o.update_value = par;
        end
      end else if (cmd == minute_q) begin
        if (set_en_q) begin
          job_o.update_kind  = UpdMinute;
          job_o.update_value = par;
        end
      end else if (cmd == second_q) begin
        if (set_en_q) begin
          job_o.update_kind  = UpdSecond;
          job_o.update_value = par;
        end
      end else begin
        set_en_d = set_en_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= 8'd85;
      get_q      <= 8'd1;
      rst_code_q <= 8'd2;
      mode_q     <= 8'd3;
      hour_q     <= 8'd4;
      minute_q   <= 8'd5;
      second_q   <= 8'd6;
      pos_q      <= 2'd0;
      set_en_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegStartCode:     start_q    <= cfg_data_i;
          RegCodeGetTime:   get_q      <= cfg_data_i;
          RegCodeResetTime: rst_code_q <= cfg_data_i;
          RegCodeSetMode:   mode_q     <= cfg_data_i;
          RegCodeHour:      hour_q     <= cfg_data_i;
          RegCodeMinute:    minute_q   <= cfg_data_i;
          RegCodeSecond:    second_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        pos_q    <= (pos_sel == 2'd3) ? 2'd0 : pos_sel + 2'd1;
        set_en_q <= set_en_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && pos_sel != 2'd3) begin
      store_q[pos_sel] <= rx_byte_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcfp_fifo.sv @@
// Short job queue between the front end and the back end.
// Register array with head and tail pointers. Depends on tcfp_pkg.
`default_nettype none

module tcfp_fifo import tcfp_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  job_t      wr_data_i,
  input  wire logic rd_i,
  output job_t      rd_data_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcfp_back.sv @@
// Back end: expands queued jobs into result items and holds the output register.
// A get-time job is sent as twelve reply bytes, one per cycle unless the output register is held. Depends on tcfp_pkg.
`default_nettype none

module tcfp_back import tcfp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output item_t     item_o
);

  logic [3:0] cnt_q;
  logic       out_valid_q;
  item_t      out_q, item_d;
  logic       advance;
  logic [7:0] code, now;
  logic       last_reply;

  assign advance    = !out_valid_q || pop_i;
  assign last_reply = (cnt_q == 4'(ReplyItems - 1));
  assign job_pop_o  = advance && job_valid_i && (!job_i.is_get || last_reply);
  assign empty_o    = !out_valid_q;
  assign item_o     = out_q;

  always_comb begin
    unique case (cnt_q[3:2])
      2'd0:    begin code = job_i.code[0]; now = job_i.now[0]; end
      2'd1:    begin code = job_i.code[1]; now = job_i.now[1]; end
      default: begin code = job_i.code[2]; now = job_i.now[2]; end
    endcase
    item_d = '0;
    if (job_i.is_get) begin
      item_d.has_tx      = 1'b1;
      item_d.frame_valid = 1'b1;
      item_d.last        = last_reply;
      unique case (cnt_q[1:0])
        2'd0:    item_d.tx_byte = job_i.start;
        2'd1:    item_d.tx_byte = code;
        2'd2:    item_d.tx_byte = now;
        default: item_d.tx_byte = 8'(code + now);
      endcase
    end else begin
      item_d.frame_valid   = job_i.frame_valid;
      item_d.reset_request = job_i.reset_request;
      item_d.update_kind   = job_i.update_kind;
      item_d.update_value  = job_i.update_value;
      item_d.last          = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (advance) begin
      out_valid_q <= job_valid_i;
      if (job_valid_i && job_i.is_get) begin
        cnt_q <= last_reply ? '0 : cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && job_valid_i) begin
      out_q <= item_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/time_command_frame_parser.sv @@
// Top level of the time command frame parser.
// Instantiates tcfp_front, tcfp_fifo and tcfp_back. Depends on tcfp_pkg.
//
// Usage: received bytes enter through a queue-style port (push, full) together
// with the current hour, minute and second. Each accepted byte produces result
// transactions on the output queue port (empty, pop): one transaction per byte,
// or twelve reply-byte transactions for a valid get-time frame, the final one
// marked by last. Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i while the block is idle; indexes beyond six are
// ignored.
// The front end accepts one byte per cycle while full is low. A byte's results
// pass through the job queue and then the output register. The back end delivers
// one result per cycle unless pop is held low, so a get-time frame occupies it
// for twelve results; the QueueDepth-entry job queue absorbs bytes until full rises.
// When the receiver holds pop low, the output register holds its transaction,
// the back end stops, and the queue fills until full stops the sender.
// Reset restores the register defaults, the frame position and the set
// enable, and empties the queue and the output register.
`default_nettype none

module time_command_frame_parser import tcfp_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [7:0] now_hour_i,
  input  wire logic [7:0] now_minute_i,
  input  wire logic [7:0] now_second_i,
  output logic            empty,
  input  wire logic       pop,
  output logic            has_tx_o,
  output logic [7:0]      tx_byte_o,
  output logic            frame_valid_o,
  output logic            reset_request_o,
  output logic [1:0]      update_kind_o,
  output logic [7:0]      update_value_o,
  output logic            last_o
);

  job_t  front_job, head_job;
  logic  accept, q_empty, q_pop;
  item_t item;

  assign accept = push && !full;

  tcfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .now_hour_i   (now_hour_i),
    .now_minute_i (now_minute_i),
    .now_second_i (now_second_i),
    .job_o        (front_job)
  );

  tcfp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (front_job),
    .rd_i      (q_pop),
    .rd_data_o (head_job),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  tcfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (head_job),
    .job_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (item)
  );

  assign has_tx_o        = item.has_tx;
  assign tx_byte_o       = item.tx_byte;
  assign frame_valid_o   = item.frame_valid;
  assign reset_request_o = item.reset_request;
  assign update_kind_o   = item.update_kind;
  assign update_value_o  = item.update_value;
  assign last_o          = item.last;

endmodule

`default_nettype wire
